@@ design/bmb_pkg.sv @@
// bmb_pkg: shared types and constants of the box mean blur block
package bmb_pkg;

  // field and datapath widths
  localparam int COORD_W    = 9;   // column or row inside the image, width at most 511
  localparam int ENTRY_W    = 24;  // summed-area table entry
  localparam int RSUM_W     = 16;  // running row sum, wraps at 16 bits
  localparam int ACC_W      = 32;  // window sum and divide numerator
  localparam int COUNT_W    = 18;  // clipped pixel count, up to 511 x 511
  localparam int DIVISOR_W  = COUNT_W + 1;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 9;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH_X = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH_Y = 8'd3;

  // input word
  typedef struct packed {
    logic       command;
    logic [7:0] pixel_value;
    logic [7:0] query_x;
    logic [7:0] query_y;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] mean_level;
    logic       error_flag;
  } out_word_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_Q_SETUP,
    ST_Q_READ,
    ST_Q_SUM,
    ST_Q_DIVGO,
    ST_Q_DIV
  } state_t;

endpackage

@@ design/bmb_ram.sv @@
// bmb_ram: generic synchronous ram, one write port, one registered read port
module bmb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/bmb_div.sv @@
// bmb_div: restoring divider, one quotient bit per cycle
module bmb_div #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 19,
  localparam int CNT_W = (DIVIDEND_W > 2) ? $clog2(DIVIDEND_W) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic                 running;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // trial subtract of the shifted remainder
  always_comb begin
    shifted = {rem, quotient[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (running) begin
      rem      <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

@@ design/box_mean_blur_integral.sv @@
// box_mean_blur_integral: box mean blur over a summed-area table, top level
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------
//  command  | start / busy        | cmd   (command, pixel, query x and y)
//  result   | result_valid strobe | result (mean_level, error_flag)
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  after accept, a load goes back to idle through one table read for
//  the entry above, one write of the new entry through the single table ram
//  a query goes back to idle through setup, four table reads, a sum,
//  divider start, 32 divide steps and a done cycle, then the idle cycle that
//  strobes the result; a query that fails its checks returns straight from setup
//  synchronous reset clears the sequencer and the load position; table
//  contents stay undefined and are never used before they are written
//  results are strobed for one cycle and cannot be held off
module box_mean_blur_integral #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  bmb_pkg::in_word_t                   cmd,
  output logic                                result_valid,
  output bmb_pkg::out_word_t                  result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bmb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bmb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW    = bmb_pkg::COORD_W;
  localparam int EW    = bmb_pkg::ENTRY_W;
  localparam int RW    = bmb_pkg::RSUM_W;
  localparam int AccW  = bmb_pkg::ACC_W;
  localparam int NW    = bmb_pkg::COUNT_W;
  localparam int DVW   = bmb_pkg::DIVISOR_W;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WCAP  = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
  localparam int HCAP  = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
  localparam logic [CW-1:0] WLIM = CW'(WCAP);
  localparam logic [CW-1:0] HLIM = CW'(HCAP);

  // table address of row and column
  function automatic logic [AW-1:0] tab_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(int'(r) * MAX_WIDTH + int'(c));
  endfunction

  bmb_pkg::state_t state, state_next;

  // configuration registers
  logic [CW-1:0] img_w;
  logic [CW-1:0] img_h;
  logic [7:0]    dx;
  logic [7:0]    dy;
  logic [CW-1:0] w_eff;
  logic [CW-1:0] h_eff;

  // load state
  bmb_pkg::in_word_t in_reg;
  logic [CW-1:0] load_col;
  logic [CW-1:0] load_row;
  logic [RW-1:0] row_sum;
  logic          image_loaded;
  logic          has_above;

  // query state
  logic [CW-1:0]   x1, x2, y1, y2, xm, ym;
  logic            hx, hy;
  logic [1:0]      rd_idx;
  logic            rd_vld;
  logic [1:0]      rd_tag;
  logic [AccW-1:0] acc;
  logic [NW-1:0]   count;

  // table ram ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  // divider ports
  logic            div_start;
  logic [AccW-1:0] div_dividend;
  logic [DVW-1:0]  div_divisor;
  logic            div_done;
  logic [AccW-1:0] div_quo;

  // combinational helpers
  logic          accept;
  logic          cfg_we;
  logic [CW-1:0] pos_col, pos_row;
  logic [RW-1:0] rs_new;
  logic [CW-1:0] col_inc, row_inc;
  logic [EW-1:0] above;
  logic [CW-1:0] qx9, qy9;
  logic [CW-1:0] q_x1, q_x2, q_y1, q_y2;
  logic [CW-1:0] x2_raw, y2_raw;
  logic          q_err;
  logic [CW-1:0] span_x, span_y;
  logic [AccW-1:0] term;
  logic            term_use, term_neg;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // effective image size, zero acts as one and large values clip
  always_comb begin
    w_eff = (img_w == '0) ? CW'(1) : ((img_w > WLIM) ? WLIM : img_w);
    h_eff = (img_h == '0) ? CW'(1) : ((img_h > HLIM) ? HLIM : img_h);
  end

  // load position, restarting after a finished image
  always_comb begin
    pos_col = image_loaded ? '0 : load_col;
    pos_row = image_loaded ? '0 : load_row;
    rs_new  = ((pos_col == '0) ? '0 : row_sum) + RW'(in_reg.pixel_value);
    col_inc = load_col + 1'b1;
    row_inc = load_row + 1'b1;
    above   = has_above ? mem_rdata : '0;
  end

  // query checks and clipped window corners
  always_comb begin
    qx9    = {1'b0, in_reg.query_x};
    qy9    = {1'b0, in_reg.query_y};
    q_err  = !image_loaded || (qx9 >= w_eff) || (qy9 >= h_eff);
    q_x1   = (qx9 > {1'b0, dx}) ? qx9 - {1'b0, dx} : '0;
    q_y1   = (qy9 > {1'b0, dy}) ? qy9 - {1'b0, dy} : '0;
    x2_raw = qx9 + {1'b0, dx};
    y2_raw = qy9 + {1'b0, dy};
    q_x2   = (x2_raw > w_eff - 1'b1) ? w_eff - 1'b1 : x2_raw;
    q_y2   = (y2_raw > h_eff - 1'b1) ? h_eff - 1'b1 : y2_raw;
    span_x = x2 - x1 + 1'b1;
    span_y = y2 - y1 + 1'b1;
  end

  // signed contribution of the corner read that just returned
  always_comb begin
    unique case (rd_tag)
      2'd0: begin
        term_use = 1'b1;
        term_neg = 1'b0;
      end
      2'd1: begin
        term_use = hx;
        term_neg = 1'b1;
      end
      2'd2: begin
        term_use = hy;
        term_neg = 1'b1;
      end
      default: begin
        term_use = hx && hy;
        term_neg = 1'b0;
      end
    endcase
    term = !term_use ? '0 :
           (term_neg ? -AccW'(mem_rdata) : AccW'(mem_rdata));
  end

  // table ram access
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tab_addr(load_row, load_col);
    mem_wdata = EW'(row_sum) + above;
    mem_raddr = '0;
    if (state == bmb_pkg::ST_LD_RD) begin
      mem_raddr = tab_addr((pos_row == '0) ? '0 : pos_row - 1'b1, pos_col);
    end else if (state == bmb_pkg::ST_LD_WR) begin
      mem_we = 1'b1;
    end else if (state == bmb_pkg::ST_Q_READ) begin
      unique case (rd_idx)
        2'd0:    mem_raddr = tab_addr(y2, x2);
        2'd1:    mem_raddr = tab_addr(y2, xm);
        2'd2:    mem_raddr = tab_addr(ym, x2);
        default: mem_raddr = tab_addr(ym, xm);
      endcase
    end
  end

  // divider operands: (2 sum + count) / (2 count)
  always_comb begin
    div_start    = (state == bmb_pkg::ST_Q_DIVGO);
    div_dividend = {acc[AccW-2:0], 1'b0} + AccW'(count);
    div_divisor  = {count, 1'b0};
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and busy
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    unique case (state)
      bmb_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = (cmd.command == bmb_pkg::CMD_LOAD) ? bmb_pkg::ST_LD_RD
                                                          : bmb_pkg::ST_Q_SETUP;
        end
      end
      bmb_pkg::ST_LD_RD:   state_next = bmb_pkg::ST_LD_WR;
      bmb_pkg::ST_LD_WR:   state_next = bmb_pkg::ST_IDLE;
      bmb_pkg::ST_Q_SETUP: state_next = q_err ? bmb_pkg::ST_IDLE : bmb_pkg::ST_Q_READ;
      bmb_pkg::ST_Q_READ: begin
        if (rd_idx == 2'd3) begin
          state_next = bmb_pkg::ST_Q_SUM;
        end
      end
      bmb_pkg::ST_Q_SUM:   state_next = bmb_pkg::ST_Q_DIVGO;
      bmb_pkg::ST_Q_DIVGO: state_next = bmb_pkg::ST_Q_DIV;
      bmb_pkg::ST_Q_DIV: begin
        if (div_done) begin
          state_next = bmb_pkg::ST_IDLE;
        end
      end
      default: state_next = bmb_pkg::ST_IDLE;
    endcase
  end

  // control registers: configuration, load position, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w        <= CW'(256);
      img_h        <= CW'(256);
      dx           <= 8'd1;
      dy           <= 8'd1;
      load_col     <= '0;
      load_row     <= '0;
      row_sum      <= '0;
      image_loaded <= 1'b0;
      result_valid <= 1'b0;
      rd_vld       <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rd_vld       <= (state == bmb_pkg::ST_Q_READ);

      // register writes, a size change abandons the load
      if (cfg_we) begin
        unique case (cfg_index)
          bmb_pkg::CFG_IMAGE_WIDTH: begin
            img_w        <= cfg_data;
            load_col     <= '0;
            load_row     <= '0;
            row_sum      <= '0;
            image_loaded <= 1'b0;
          end
          bmb_pkg::CFG_IMAGE_HEIGHT: begin
            img_h        <= cfg_data;
            load_col     <= '0;
            load_row     <= '0;
            row_sum      <= '0;
            image_loaded <= 1'b0;
          end
          bmb_pkg::CFG_HALF_WIDTH_X: dx <= cfg_data[7:0];
          bmb_pkg::CFG_HALF_WIDTH_Y: dy <= cfg_data[7:0];
          default: ;
        endcase
      end

      // load position and row sum
      if (state == bmb_pkg::ST_LD_RD) begin
        load_col     <= pos_col;
        load_row     <= pos_row;
        row_sum      <= rs_new;
        image_loaded <= 1'b0;
      end else if (state == bmb_pkg::ST_LD_WR) begin
        if (col_inc >= w_eff) begin
          load_col <= '0;
          if (row_inc >= h_eff) begin
            load_row     <= '0;
            image_loaded <= 1'b1;
          end else begin
            load_row <= row_inc;
          end
        end else begin
          load_col <= col_inc;
        end
      end

      // result strobe
      if ((state == bmb_pkg::ST_Q_SETUP && q_err) ||
          (state == bmb_pkg::ST_Q_DIV && div_done)) begin
        result_valid <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= cmd;
    end

    if (state == bmb_pkg::ST_LD_RD) begin
      has_above <= (pos_row != '0);
    end

    // window setup
    if (state == bmb_pkg::ST_Q_SETUP) begin
      x1     <= q_x1;
      x2     <= q_x2;
      y1     <= q_y1;
      y2     <= q_y2;
      xm     <= (q_x1 == '0) ? '0 : q_x1 - 1'b1;
      ym     <= (q_y1 == '0) ? '0 : q_y1 - 1'b1;
      hx     <= (q_x1 != '0);
      hy     <= (q_y1 != '0);
      rd_idx <= '0;
      acc    <= '0;
      if (q_err) begin
        result.mean_level <= 8'd0;
        result.error_flag <= 1'b1;
      end
    end

    // corner reads
    if (state == bmb_pkg::ST_Q_READ) begin
      rd_idx <= rd_idx + 1'b1;
      rd_tag <= rd_idx;
      if (rd_idx == 2'd0) begin
        count <= NW'(span_x * span_y);
      end
    end

    // window sum
    if (rd_vld) begin
      acc <= acc + term;
    end

    // rounded mean, clipped to the pixel range
    if (state == bmb_pkg::ST_Q_DIV && div_done) begin
      result.mean_level <= (|div_quo[AccW-1:8]) ? 8'hFF : div_quo[7:0];
      result.error_flag <= 1'b0;
    end
  end

  bmb_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bmb_div #(
    .DIVIDEND_W (AccW),
    .DIVISOR_W  (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

@@ design/bmb_chk.sv @@
// bmb_chk: port-level checks of the box mean blur block and its bind
module bmb_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           result_valid,
  input bmb_pkg::out_word_t             result
);

  // an accepted word always keeps the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not make the block busy");

  // results never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for two cycles");

  // an error result carries a zero mean
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error_flag |-> result.mean_level == 8'd0)
    else $error("error result with nonzero mean");

  // a result only follows work in progress
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a word in progress");

endmodule

bind box_mean_blur_integral bmb_chk u_bmb_chk (.*);
